// File: src/grid_strip_index_generator_macros.svh
// ----------------------------------------------------------------------------
// grid strip index generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef GRID_STRIP_INDEX_GENERATOR_MACROS_SVH
`define GRID_STRIP_INDEX_GENERATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define GSIG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GSIG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gsig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsig_pkg
// Widths, register indexes and shared types of the grid strip index generator.
// ----------------------------------------------------------------------------
package gsig_pkg;

  // register field widths
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 11;
  localparam int STEP_W   = 10;
  localparam int STRIDE_W = 11;

  // state widths
  localparam int ROW_W = 11;
  localparam int COL_W = 12;

  // result width
  localparam int INDEX_W = 20;

  // stream bus widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 2'd3;

  // status of a quotient parity unit
  typedef struct packed {
    logic busy;
    logic done;
    logic parity;
  } par_stat_t;

endpackage

// File: src/gsig_par_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsig_par_div
// Restoring bit-serial divider that returns the parity of floor(a / s).
// ----------------------------------------------------------------------------
module gsig_par_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gsig_pkg::ROW_W-1:0]    dividend,
  input  logic [gsig_pkg::STEP_W-1:0]   divisor,
  output gsig_pkg::par_stat_t           stat
);
  import gsig_pkg::*;

  localparam int CNT_W = $clog2(ROW_W);

  logic [ROW_W-1:0]  dvd;
  logic [STEP_W-1:0] dsr;
  logic [STEP_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic              parity;

  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;
  logic              ge;

  // one quotient bit per cycle, msb first
  always_comb begin
    trial = {rem, dvd[ROW_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= CNT_W'(ROW_W - 1);
    end else if (busy) begin
      dvd <= {dvd[ROW_W-2:0], 1'b0};
      rem <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        parity <= ge;
      end
    end
  end

  assign stat.busy   = busy;
  assign stat.done   = done;
  assign stat.parity = parity;

endmodule

// File: src/grid_strip_index_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_strip_index_generator
// Serpentine triangle strip vertex indices over a grid subsampled by a step.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tdata: restart
//  m       | out | m_tvalid/m_tready  | m_tdata: vertex_index, m_tlast:
//          |     |                    | last_index, m_tuser: bad_config
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// One beat in, one beat out; a beat is taken every cycle while s_tready is
// high, and its index is loaded into the output register at the accepting
// edge, the multiply-add setting the path. rst is synchronous and rewinds
// the strip and loads default registers. A register write starts two serial
// parity divisions in the cycle after it (11 steps); s_tready stays low after
// the last write while the units load, run their 11 steps and give the parity.
// The output register frees on m_tready, so a stall holds the input side.
// ----------------------------------------------------------------------------
`include "grid_strip_index_generator_macros.svh"

module grid_strip_index_generator #(
  parameter int MAX_DIM = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // bit 0: restart
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gsig_pkg::IN_TDATA_W-1:0]     s_tdata,
  // bits 19:0: vertex_index
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gsig_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  // bit 0: bad_config
  output logic [0:0]                          m_tuser,
  input  logic                                cfg_we,
  input  logic [gsig_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gsig_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gsig_pkg::*;

  localparam logic [31:0] MAX_DIM_U = 32'(MAX_DIM);

  // configuration registers
  logic [WIDTH_W-1:0]  grid_width;
  logic [HEIGHT_W-1:0] grid_height;
  logic [STEP_W-1:0]   grid_step;
  logic [STRIDE_W-1:0] row_stride;
  logic                cfg_we_q;

  // sequence state
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic [COL_W-1:0] turn_col;
  logic             bottom_half;
  logic             edge_lead;
  logic             row_parity;
  // parity of row_pos / step and of final row / step
  logic             rp_par;
  logic             lr_par;

  // next state
  logic [ROW_W-1:0] row_pos_next;
  logic [COL_W-1:0] col_pos_next;
  logic [COL_W-1:0] turn_col_next;
  logic             bottom_half_next;
  logic             edge_lead_next;
  logic             row_parity_next;
  logic             rp_par_next;

  // working values
  logic [ROW_W-1:0]    w;
  logic [ROW_W-1:0]    h;
  logic [STRIDE_W-1:0] r;
  logic                bad;
  logic [ROW_W-1:0]    last_row;
  logic [COL_W-1:0]    last_col;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [COL_W-1:0]    cur_turn;
  logic                cur_bottom;
  logic                cur_edge;
  logic                cur_parity;
  logic                cur_rp_par;
  logic [ROW_W-1:0]    hor;
  logic                hor_par;
  logic [COL_W-1:0]    ver;
  logic [ROW_W-1:0]    rowv;
  logic [ROW_W+STRIDE_W-1:0] prod;
  logic [INDEX_W-1:0]  idx;
  logic [COL_W-1:0]    col_adv;
  logic [ROW_W-1:0]    nx;
  logic                row_done;
  logic                fin;

  logic                accept;
  logic                div_busy;
  par_stat_t           rp_stat;
  par_stat_t           lr_stat;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= WIDTH_W'(2);
      grid_height <= HEIGHT_W'(2);
      grid_step   <= STEP_W'(1);
      row_stride  <= STRIDE_W'(2);
      cfg_we_q    <= 1'b0;
    end else begin
      cfg_we_q <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data[WIDTH_W-1:0];
          CFG_GRID_HEIGHT: grid_height <= cfg_data[HEIGHT_W-1:0];
          CFG_GRID_STEP:   grid_step   <= cfg_data[STEP_W-1:0];
          CFG_ROW_STRIDE:  row_stride  <= cfg_data[STRIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // saturated dimensions and validity
  always_comb begin
    w = (32'(grid_width) > MAX_DIM_U) ? MAX_DIM_U[ROW_W-1:0] : grid_width;
    h = (32'(grid_height) > MAX_DIM_U) ? MAX_DIM_U[ROW_W-1:0] : grid_height;
    r = (32'(row_stride) > MAX_DIM_U) ? MAX_DIM_U[STRIDE_W-1:0] : row_stride;
    bad = (grid_step == '0) || (w == '0) || (h <= {1'b0, grid_step});
    last_row = h - {1'b0, grid_step} - ROW_W'(1);
    last_col = {1'b0, w} - COL_W'(1);
  end

  // quotient parity units, loaded the cycle after a register write
  gsig_par_div u_rp_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_we_q),
    .dividend (row_pos),
    .divisor  (grid_step),
    .stat     (rp_stat)
  );

  gsig_par_div u_lr_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_we_q),
    .dividend (last_row),
    .divisor  (grid_step),
    .stat     (lr_stat)
  );

  // input held off until both parities are taken
  assign div_busy = cfg_we_q || rp_stat.busy || lr_stat.busy || rp_stat.done || lr_stat.done;
  assign s_tready = (!m_tvalid || m_tready) && !div_busy;
  assign accept   = s_tvalid && s_tready;

  // current vertex and next position
  always_comb begin
    // restart rewinds before use
    if (s_tdata[0]) begin
      cur_row    = '0;
      cur_col    = '0;
      cur_turn   = '0;
      cur_bottom = 1'b0;
      cur_edge   = 1'b0;
      cur_parity = 1'b0;
      cur_rp_par = 1'b0;
    end else begin
      cur_row    = row_pos;
      cur_col    = col_pos;
      cur_turn   = turn_col;
      cur_bottom = bottom_half;
      cur_edge   = edge_lead;
      cur_parity = row_parity;
      cur_rp_par = rp_par;
    end

    // clamp stored row and column to the current grid
    hor     = (cur_row < last_row) ? cur_row : last_row;
    hor_par = (cur_row < last_row) ? cur_rp_par : lr_par;
    if (cur_parity && cur_edge) begin
      ver = last_col;
    end else begin
      ver = (cur_col < last_col) ? cur_col : last_col;
    end

    // index
    rowv = cur_bottom ? (hor + ROW_W'(grid_step)) : hor;
    prod = (ROW_W+STRIDE_W)'(rowv) * (ROW_W+STRIDE_W)'(r);
    idx  = prod[INDEX_W-1:0] + INDEX_W'(ver);

    // defaults: hold, but the vertex half toggles
    row_pos_next     = cur_row;
    col_pos_next     = cur_col;
    turn_col_next    = cur_turn;
    bottom_half_next = !cur_bottom;
    edge_lead_next   = cur_edge;
    row_parity_next  = cur_parity;
    rp_par_next      = cur_rp_par;
    row_done         = 1'b0;
    fin              = 1'b0;
    col_adv          = ver + COL_W'(grid_step);
    nx               = hor + ROW_W'(grid_step);

    // column advance after the bottom vertex
    if (cur_bottom) begin
      if (!cur_parity) begin
        if (ver == last_col) begin
          row_done = 1'b1;
        end else if (col_adv >= last_col) begin
          turn_col_next = ver;
          col_pos_next  = last_col;
        end else begin
          col_pos_next = col_adv;
        end
      end else if (cur_edge) begin
        edge_lead_next = 1'b0;
        col_pos_next   = cur_turn;
      end else begin
        if (ver == '0) begin
          row_done = 1'b1;
        end else if (ver >= COL_W'(grid_step)) begin
          col_pos_next = ver - COL_W'(grid_step);
        end else begin
          col_pos_next = '0;
        end
      end
    end

    // row advance or end of strip
    if (row_done) begin
      if (hor == last_row) begin
        fin              = 1'b1;
        row_pos_next     = '0;
        col_pos_next     = '0;
        turn_col_next    = '0;
        bottom_half_next = 1'b0;
        edge_lead_next   = 1'b0;
        row_parity_next  = 1'b0;
        rp_par_next      = 1'b0;
      end else begin
        if (nx > last_row) begin
          row_pos_next = last_row;
          rp_par_next  = lr_par;
        end else begin
          row_pos_next = nx;
          rp_par_next  = !hor_par;
        end
        row_parity_next = rp_par_next;
        if (rp_par_next) begin
          edge_lead_next = 1'b1;
          col_pos_next   = last_col;
        end else begin
          edge_lead_next = 1'b0;
          col_pos_next   = '0;
          if (last_col == '0) begin
            turn_col_next = '0;
          end
        end
      end
    end

    // invalid grid rewinds
    if (bad) begin
      row_pos_next     = '0;
      col_pos_next     = '0;
      turn_col_next    = '0;
      bottom_half_next = 1'b0;
      edge_lead_next   = 1'b0;
      row_parity_next  = 1'b0;
      rp_par_next      = 1'b0;
    end
  end

  // sequence state and parity bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos     <= '0;
      col_pos     <= '0;
      turn_col    <= '0;
      bottom_half <= 1'b0;
      edge_lead   <= 1'b0;
      row_parity  <= 1'b0;
      rp_par      <= 1'b0;
      lr_par      <= 1'b0;
    end else if (accept) begin
      row_pos     <= row_pos_next;
      col_pos     <= col_pos_next;
      turn_col    <= turn_col_next;
      bottom_half <= bottom_half_next;
      edge_lead   <= edge_lead_next;
      row_parity  <= row_parity_next;
      rp_par      <= rp_par_next;
    end else if (rp_stat.done) begin
      rp_par <= rp_stat.parity;
      lr_par <= lr_stat.parity;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata    <= bad ? '0 : OUT_TDATA_W'(idx);
      m_tlast    <= bad ? 1'b1 : fin;
      m_tuser[0] <= bad;
    end
  end

  // checks
  `GSIG_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !s_tready, "input taken right after a write")
  `GSIG_ASSERT_NOW(a_no_accept_in_div, div_busy, !s_tready, "input taken during division")
  `GSIG_ASSERT_NOW(a_bad_is_last, m_tvalid && m_tuser[0], m_tlast, "bad config beat not last")
  `GSIG_ASSERT_NEXT(a_last_rewinds, accept && fin && !bad, (row_pos == '0) && !bottom_half, "no rewind after last")
  `GSIG_ASSERT_NEXT(a_half_toggles, accept && !bad && !s_tdata[0], bottom_half != $past(bottom_half), "vertex half did not toggle")

endmodule
